/* sv/ssm_pkg.sv */
package ssm_pkg;
    localparam int NUM_LANES   = 8;
    localparam int NUM_STEPS   = 16;
    localparam int LANE_W      = 3;
    localparam int STEP_W      = 4;
    localparam int LEN_W       = 5;
    localparam int TGT_W       = 8;
    localparam int VAL_W       = 16;
    localparam int BPS_W       = 41;
    localparam logic [TGT_W-1:0] TARGET_NONE = 8'd255;
    localparam logic [BPS_W-1:0] MIN_BEATS_PER_STEP = 41'd4295;

    localparam logic [1:0] FUNC_STEP    = 2'd0;
    localparam logic [1:0] FUNC_SETUP   = 2'd1;
    localparam logic [1:0] FUNC_PUBLISH = 2'd2;
    localparam logic [1:0] FUNC_BLOCK   = 2'd3;

    typedef struct packed {
        logic       item;
        logic       div_start;
        logic       lane_start;
        logic       search_step;
        logic       claim;
        logic       out_load;
        logic       next_lane;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       found;
        logic       search_end;
        logic       last_lane;
        logic       out_busy;
    } t_status;
endpackage

/* sv/ssm_ctrl.sv */
module ssm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item,
    input  logic [1:0]      i_func,
    input  ssm_pkg::t_status i_status,
    output logic            o_ready,
    output ssm_pkg::t_cmd   o_cmd
);
    import ssm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_LANE = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.item = i_item;
        unique case (r_state)
            S_IDLE: begin
                if (i_item && i_func == FUNC_BLOCK) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_LANE;
                end
            end
            S_LANE: begin
                o_cmd.lane_start = 1'b1;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if (i_status.found || i_status.search_end) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.claim    = 1'b1;
                    if (i_status.last_lane) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_lane = 1'b1;
                        n_state = S_LANE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* sv/ssm_div.sv */
module ssm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [40:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [40:0] r_rem;
    logic [40:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [41:0] w_trial;
    logic [41:0] w_diff;

    assign w_trial = {r_rem, r_q[63]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == 7'd0);
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!w_diff[41]) begin
                r_rem <= w_diff[40:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_trial[40:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

/* sv/ssm_dp.sv */
module ssm_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [40:0]     i_cfg_data,
    input  ssm_pkg::t_cmd   i_cmd,
    input  logic [150:0]    i_data,
    input  logic [1:0]      i_func,
    output ssm_pkg::t_status o_status,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [31:0]     o_out_data,
    output logic            o_out_last
);
    import ssm_pkg::*;

    logic [LANE_W-1:0] w_lane;
    logic [STEP_W-1:0] w_sidx;
    logic [VAL_W-1:0]  w_sval;
    logic              w_sgate;
    logic [TGT_W-1:0]  w_tgt;
    logic              w_en;
    logic [LEN_W-1:0]  w_len;
    logic              w_play;
    logic [63:0]       w_song;
    logic [31:0]       w_bps;
    logic [15:0]       w_ns;
    logic [47:0]       w_prod;

    assign w_lane  = i_data[2:0];
    assign w_sidx  = i_data[6:3];
    assign w_sval  = i_data[22:7];
    assign w_sgate = i_data[23];
    assign w_tgt   = i_data[31:24];
    assign w_en    = i_data[32];
    assign w_len   = i_data[37:33];
    assign w_play  = i_data[38];
    assign w_song  = i_data[102:39];
    assign w_bps   = i_data[134:103];
    assign w_ns    = i_data[150:135];
    assign w_prod  = w_bps * w_ns;

    // step memory: bank, lane, step
    logic [16:0] r_mem [0:255];
    logic [16:0] r_rd;
    logic [TGT_W-1:0] r_stgt [0:15];
    logic             r_sen  [0:15];
    logic [LEN_W-1:0] r_slen [0:15];
    logic [15:0]      r_svalid;
    logic [255:0]     r_mvalid;
    logic             r_live;
    logic [63:0]      r_free;
    logic [40:0]      r_bpstep;
    logic [40:0]      w_den;

    // block item fields
    logic [63:0] r_start;
    logic [63:0] r_adv;
    logic        r_neg;
    logic [63:0] w_mag;
    logic [63:0] w_num;
    logic        w_dd;
    logic [63:0] w_q;

    assign w_den = (r_bpstep < MIN_BEATS_PER_STEP) ? MIN_BEATS_PER_STEP : r_bpstep;

    logic [63:0] w_pos_sel;
    assign w_pos_sel = w_play ? w_song : r_free;
    assign w_mag = 64'd0 - w_pos_sel;
    assign w_num = w_pos_sel[63] ? (w_mag + {23'd0, w_den} - 64'd1) : w_pos_sel;

    ssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_dd),
        .o_quot  (w_q)
    );

    logic [63:0] r_quot;
    logic [LANE_W-1:0] r_cur;
    logic [LEN_W-1:0]  r_clen;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] r_k;
    logic [LEN_W-1:0]  r_back;
    logic              r_rdv;
    logic              r_found;
    logic              r_send;
    logic [VAL_W-1:0]  r_hval;
    logic [TGT_W-1:0]  r_claim [0:NUM_LANES-1];
    logic [3:0]        r_ccount;

    logic [3:0]  w_sidx_live;
    logic [LEN_W-1:0] w_rawlen;
    logic [LEN_W-1:0] w_cl;
    logic [TGT_W-1:0] w_ltgt;
    logic             w_len_en;
    assign w_sidx_live = {r_live, r_cur};
    assign w_rawlen = r_svalid[w_sidx_live] ? r_slen[w_sidx_live] : 5'(NUM_STEPS);
    assign w_cl = (w_rawlen == 5'd0) ? 5'd1 :
                  (w_rawlen > 5'(NUM_STEPS)) ? 5'(NUM_STEPS) : w_rawlen;
    assign w_ltgt = r_svalid[w_sidx_live] ? r_stgt[w_sidx_live] : TARGET_NONE;
    assign w_len_en = r_svalid[w_sidx_live] && r_sen[w_sidx_live] && (w_ltgt != TARGET_NONE);

    // quotient mod length: quotient is 64 bit, folded in MSB first
    logic [4:0] w_mod;
    logic [4:0] r_mod;
    logic [6:0] r_mcnt;
    logic       r_mbusy;
    logic [5:0] w_madd;
    assign w_madd = {r_mod, r_quot[63]};
    assign w_mod  = (w_madd >= {1'b0, w_cl}) ? 5'(w_madd - {1'b0, w_cl}) : w_madd[4:0];

    logic [4:0] w_stepv;
    assign w_stepv = (r_neg && r_mod != 5'd0) ? 5'(w_cl - r_mod) : r_mod;

    logic [7:0] w_addr;
    assign w_addr = {r_live, r_cur, r_k};

    logic w_taken;
    always_comb begin
        w_taken = 1'b0;
        for (int j = 0; j < NUM_LANES; j++) begin
            if (4'(j) < r_ccount && r_claim[j] == w_ltgt) begin
                w_taken = 1'b1;
            end
        end
    end

    logic w_app;
    assign w_app = w_len_en && r_found && !w_taken;

    assign o_status.div_done   = 1'b0 | (w_dd && 1'b1);
    assign o_status.found      = (r_found || !w_len_en) && !r_mbusy;
    assign o_status.search_end = r_send;
    assign o_status.last_lane  = (r_cur == 3'(NUM_LANES - 1));
    assign o_status.out_busy   = o_out_valid && !i_out_ready;

    logic [7:0] w_wa;
    assign w_wa = {~r_live, w_lane, w_sidx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.item && i_func == FUNC_STEP) begin
            r_mem[w_wa] <= {w_sgate, w_sval};
        end
        r_rd <= r_mem[w_addr];
        if (i_cmd.item && i_func == FUNC_SETUP) begin
            r_stgt[{~r_live, w_lane}] <= w_tgt;
            r_sen[{~r_live, w_lane}]  <= w_en;
            r_slen[{~r_live, w_lane}] <= w_len;
        end
        if (i_cmd.claim && w_app) begin
            r_claim[r_ccount[2:0]] <= w_ltgt;
        end
    end

    logic [64:0] w_sum;
    assign w_sum = {r_start[63], r_start} + {1'b0, r_adv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svalid  <= '0;
            r_mvalid  <= '0;
            r_live    <= 1'b0;
            r_free    <= '0;
            r_bpstep  <= 41'd1073741824;
            r_ccount  <= '0;
            r_cur     <= '0;
            r_mbusy   <= 1'b0;
            r_rdv     <= 1'b0;
            r_found   <= 1'b0;
            r_send    <= 1'b0;
            r_back    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bpstep <= i_cfg_data;
            end
            if (i_cmd.item && i_func == FUNC_STEP) begin
                r_mvalid[w_wa] <= 1'b1;
            end
            if (i_cmd.item && i_func == FUNC_SETUP) begin
                r_svalid[{~r_live, w_lane}] <= 1'b1;
            end
            if (i_cmd.item && i_func == FUNC_PUBLISH) begin
                r_live <= ~r_live;
            end
            if (i_cmd.div_start) begin
                r_start  <= w_pos_sel;
                r_neg    <= w_pos_sel[63];
                r_adv    <= {16'd0, w_prod};
                r_ccount <= '0;
                r_cur    <= '0;
            end
            if (w_dd) begin
                r_quot <= w_q;
                if (!r_start[63] && w_sum[64:63] == 2'b01) begin
                    r_free <= 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    r_free <= w_sum[63:0];
                end
            end
            if (i_cmd.lane_start) begin
                r_mod   <= '0;
                r_mcnt  <= 7'd64;
                r_mbusy <= 1'b1;
                r_found <= 1'b0;
                r_send  <= 1'b0;
                r_back  <= '0;
                r_rdv   <= 1'b0;
            end else if (r_mbusy) begin
                r_quot <= {r_quot[62:0], r_quot[63]};
                r_mod  <= w_mod;
                r_mcnt <= r_mcnt - 7'd1;
                if (r_mcnt == 7'd1) begin
                    r_mbusy <= 1'b0;
                end
            end else if (i_cmd.search_step) begin
                if (r_back == 5'd0 && !r_rdv) begin
                    r_step <= w_stepv[3:0];
                    r_k    <= w_stepv[3:0];
                    r_back <= 5'd1;
                    r_rdv  <= 1'b1;
                end else if (r_rdv) begin
                    r_rdv <= 1'b0;
                end else if (r_mvalid[w_addr] && r_rd[16]) begin
                    r_found <= 1'b1;
                    r_hval  <= r_rd[15:0];
                end else if (r_back != w_cl) begin
                    r_k    <= (r_k == 4'd0) ? 4'(w_cl - 5'd1) : r_k - 4'd1;
                    r_back <= r_back + 5'd1;
                    r_rdv  <= 1'b1;
                end else begin
                    r_send <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
                o_out_last  <= o_status.last_lane;
                o_out_data  <= {(w_app ? r_hval : 16'd0),
                                (w_app ? w_ltgt : 8'd0), w_app,
                                (r_back == 5'd0) ? w_stepv[3:0] : r_step, r_cur};
                if (w_app) begin
                    r_ccount <= r_ccount + 4'd1;
                end
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.next_lane) begin
                r_cur <= r_cur + 3'd1;
            end
        end
    end
endmodule

/* sv/step_sequencer_modulation_top.sv */
// sequence: a block item first runs the divide, then for each lane in turn a set-up,
// a modulo reduction of the quotient, a search of the steps and a load of the output word
// flow: a block item holds the input until the last lane's word is loaded, output stalls included;
// write, setup and publish items are taken back to back while idle
// reset: synchronous active low; store entries read as cleared until written
module step_sequencer_modulation_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [40:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,  // func
    // lane, step_index, step_value, step_gate, lane_target, lane_enabled, lane_length,
    // playing, song_position, beats_per_sample, num_samples
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lane_number, current_step, applies, target, value
    output logic [31:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import ssm_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_item;
    logic    w_rdy;

    assign s_axis_tready = w_rdy;
    assign w_item = s_axis_tvalid && w_rdy;

    ssm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_func   (s_axis_tuser),
        .i_status (w_st),
        .o_ready  (w_rdy),
        .o_cmd    (w_cmd)
    );

    ssm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_data      (s_axis_tdata[150:0]),
        .i_func      (s_axis_tuser),
        .o_status    (w_st),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule
